[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

`endif

[rtl/tftp_pkg.sv]
// Shared types, codes and defaults of the TFTP client transfer controller.
package tftp_pkg;

  localparam int BLOCK_BYTES_DEF    = 512;
  localparam int BLOCK_NUM_BITS_DEF = 16;

  localparam int FILE_LEN_W = 25;
  localparam int BLK_W      = 16;
  localparam int DLEN_W     = 10;
  localparam int OP_W       = 16;
  localparam int ECODE_W    = 16;
  localparam int TICK_W     = 32;
  localparam int TRY_W      = 4;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  // Event codes on the cmd field.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_PKT   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Received opcodes.
  localparam logic [OP_W-1:0] OP_DATA  = 16'd3;
  localparam logic [OP_W-1:0] OP_ACK   = 16'd4;
  localparam logic [OP_W-1:0] OP_ERROR = 16'd5;

  // What to send.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_REQ  = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;
  localparam logic [1:0] KIND_DATA = 2'd3;

  // Session end status.
  localparam logic [1:0] STAT_NONE  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_PEER  = 2'd2;
  localparam logic [1:0] STAT_RETRY = 2'd3;

  // Register indexes (word address bits of paddr).
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_RETRY   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_FILELEN = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_WREQ,
    PH_WDATA
  } phase_t;

  typedef struct packed {
    logic [1:0]         send_kind;
    logic [BLK_W-1:0]   send_block;
    logic [DLEN_W-1:0]  send_length;
    logic               store_payload;
    logic [1:0]         status;
    logic [ECODE_W-1:0] peer_error;
  } res_t;

endpackage

[rtl/tftp_blk_len.sv]
// Payload length of a write-mode block, derived from the file length.
module tftp_blk_len
  import tftp_pkg::*;
#(
  parameter int BLOCK_BYTES    = BLOCK_BYTES_DEF,
  parameter int BLOCK_NUM_BITS = BLOCK_NUM_BITS_DEF
) (
  input  logic [BLOCK_NUM_BITS-1:0]          blk,
  input  logic [FILE_LEN_W-1:0]              file_length,
  output logic [$clog2(BLOCK_BYTES+1)-1:0]   len
);

  localparam int LEN_W = $clog2(BLOCK_BYTES + 1);
  localparam int OFF_W = BLOCK_NUM_BITS + LEN_W;
  localparam int CMP_W = (OFF_W > FILE_LEN_W) ? OFF_W : FILE_LEN_W;
  localparam logic [OFF_W-1:0] BYTES_OFF = OFF_W'(BLOCK_BYTES);
  localparam logic [CMP_W-1:0] BYTES_CMP = CMP_W'(BLOCK_BYTES);

  logic [BLOCK_NUM_BITS-1:0] blk_m1;
  logic [OFF_W-1:0]          off;
  logic [CMP_W-1:0]          off_x;
  logic [CMP_W-1:0]          fl_x;
  logic [CMP_W-1:0]          rem;

  // Block zero is treated as block one.
  assign blk_m1 = (blk == '0) ? '0 : blk - BLOCK_NUM_BITS'(1);
  assign off    = OFF_W'(blk_m1) * BYTES_OFF;
  assign off_x  = CMP_W'(off);
  assign fl_x   = CMP_W'(file_length);
  assign rem    = fl_x - off_x;

  always_comb begin
    if (off_x >= fl_x) begin
      len = '0;
    end else if (rem > BYTES_CMP) begin
      len = LEN_W'(BLOCK_BYTES);
    end else begin
      len = LEN_W'(rem);
    end
  end

endmodule

[rtl/tftp_client_transfer_fsm.sv]
// Top level of the stop-and-wait TFTP client transfer controller.
//
// This block is the control side of a TFTP client. Each input beat is one
// event: a start command, a parsed received packet, or one timer tick. Each
// event yields exactly one result beat telling the packet layer what to send
// (request, ack or data block with its length), whether the received payload
// must be stored, and, on the beat that ends a session, the final status.
// An event is registered on acceptance, decoded by short logic against the
// session state, and the result lands in an output register; the input
// register moves an event on only when the result register is empty or its
// result is being taken. One event is taken every cycle as long as the result
// side keeps up; the only limit on rate is the single output register, which
// holds a result while out_stall is high.
// Configuration goes through the APB-style port and is expected to change
// only while no session event is in flight. There is no clearing pass after
// reset; the block accepts events from the first cycle out of reset.
module tftp_client_transfer_fsm
  import tftp_pkg::*;
#(
  parameter int BLOCK_BYTES    = BLOCK_BYTES_DEF,
  parameter int BLOCK_NUM_BITS = BLOCK_NUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // Event channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [OP_W-1:0]     pkt_opcode,
  input  logic [BLK_W-1:0]    pkt_block,
  input  logic [DLEN_W-1:0]   pkt_data_len,
  input  logic [ECODE_W-1:0]  pkt_error_code,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          send_kind,
  output logic [BLK_W-1:0]    send_block,
  output logic [DLEN_W-1:0]   send_length,
  output logic                store_payload,
  output logic [1:0]          status,
  output logic [ECODE_W-1:0]  peer_error
);

  localparam int BNB   = BLOCK_NUM_BITS;
  localparam int LEN_W = $clog2(BLOCK_BYTES + 1);

  // Configuration registers.
  logic                  transfer_mode;
  logic [TRY_W-1:0]      retry_limit;
  logic [TICK_W-1:0]     timeout_ticks;
  logic [FILE_LEN_W-1:0] file_length;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_mode <= 1'b0;
      retry_limit   <= TRY_W'(5);
      timeout_ticks <= TICK_W'(1000000);
      file_length   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:    transfer_mode <= pwdata[0];
        REG_RETRY:   retry_limit   <= pwdata[TRY_W-1:0];
        REG_TIMEOUT: timeout_ticks <= pwdata[TICK_W-1:0];
        REG_FILELEN: file_length   <= pwdata[FILE_LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:    prdata = DATA_W'(transfer_mode);
      REG_RETRY:   prdata = DATA_W'(retry_limit);
      REG_TIMEOUT: prdata = DATA_W'(timeout_ticks);
      REG_FILELEN: prdata = DATA_W'(file_length);
      default:     prdata = '0;
    endcase
  end

  // Input register. It takes a new beat whenever its current one moves on
  // into the result register in the same cycle.
  logic                ir_valid;
  logic [1:0]          ir_cmd;
  logic [OP_W-1:0]     ir_op;
  logic [BLK_W-1:0]    ir_block;
  logic [DLEN_W-1:0]   ir_dlen;
  logic [ECODE_W-1:0]  ir_ecode;
  logic                advance;

  assign advance  = ir_valid && (!out_valid || !out_stall);
  assign in_stall = ir_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!in_stall) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_cmd   <= cmd;
      ir_op    <= pkt_opcode;
      ir_block <= pkt_block;
      ir_dlen  <= pkt_data_len;
      ir_ecode <= pkt_error_code;
    end
  end

  // Session state.
  phase_t                phase, phase_next;
  logic [BNB-1:0]        block_count, block_count_next;
  logic [TRY_W-1:0]      tries_used, tries_used_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic                  peer_answered, peer_answered_next;
  logic [DLEN_W-1:0]     last_sent_length, last_sent_length_next;

  // Event decode.
  logic           active;
  logic           ev_start, ev_tick, ev_pkt, ev_err;
  logic           tick_expire, limit_hit;
  logic           rd_data, rd_new, rd_short;
  logic           wr_ack, ack_match;
  logic [BNB-1:0] rx_blk;
  logic [BNB-1:0] next_blk;
  logic [LEN_W-1:0] next_len;
  logic [LEN_W-1:0] cur_len;
  logic           cur_full;
  logic [TRY_W-1:0] eff_limit;
  logic [TICK_W-1:0] eff_timeout;

  assign active      = (phase != PH_IDLE);
  assign ev_start    = (ir_cmd == CMD_START);
  assign ev_tick     = (ir_cmd == CMD_TICK) && active;
  assign ev_pkt      = (ir_cmd == CMD_PKT) && active;
  assign ev_err      = ev_pkt && (ir_op == OP_ERROR);
  assign eff_timeout = (timeout_ticks == '0) ? TICK_W'(1) : timeout_ticks;
  assign tick_expire = ({1'b0, tick_count} + (TICK_W+1)'(1)) >= {1'b0, eff_timeout};
  assign eff_limit   = (retry_limit == '0) ? TRY_W'(1) : retry_limit;
  assign limit_hit   = (tries_used >= eff_limit);
  assign rx_blk      = ir_block[BNB-1:0];
  assign rd_data     = ev_pkt && (phase == PH_READ) && (ir_op == OP_DATA);
  assign rd_new      = (rx_blk > block_count);
  assign rd_short    = (32'(ir_dlen) != 32'(BLOCK_BYTES));
  assign wr_ack      = ev_pkt && (phase != PH_READ) && (ir_op == OP_ACK);
  assign ack_match   = (rx_blk == block_count);
  // The block that a data send would carry next: block one after the ACK of
  // the request, otherwise the one after the current block.
  assign next_blk    = (phase == PH_WREQ) ? BNB'(1) : block_count + BNB'(1);
  // A current block shorter than a full one is the last of the file; its
  // length follows the file length as it stands now.
  assign cur_full    = (32'(cur_len) == 32'(BLOCK_BYTES));

  tftp_blk_len #(
    .BLOCK_BYTES    (BLOCK_BYTES),
    .BLOCK_NUM_BITS (BLOCK_NUM_BITS)
  ) u_blk_len (
    .blk         (next_blk),
    .file_length (file_length),
    .len         (next_len)
  );

  tftp_blk_len #(
    .BLOCK_BYTES    (BLOCK_BYTES),
    .BLOCK_NUM_BITS (BLOCK_NUM_BITS)
  ) u_cur_len (
    .blk         (block_count),
    .file_length (file_length),
    .len         (cur_len)
  );

  // Next session state.
  always_comb begin
    phase_next            = phase;
    block_count_next      = block_count;
    tries_used_next       = tries_used;
    tick_count_next       = tick_count;
    peer_answered_next    = peer_answered;
    last_sent_length_next = last_sent_length;
    priority if (ev_start) begin
      phase_next            = transfer_mode ? PH_WREQ : PH_READ;
      block_count_next      = '0;
      tries_used_next       = TRY_W'(1);
      tick_count_next       = '0;
      peer_answered_next    = 1'b0;
      last_sent_length_next = '0;
    end else if (ev_tick) begin
      if (!tick_expire) begin
        tick_count_next = tick_count + TICK_W'(1);
      end else begin
        tick_count_next = '0;
        if (limit_hit) begin
          phase_next = PH_IDLE;
        end else begin
          tries_used_next = tries_used + TRY_W'(1);
        end
      end
    end else if (ev_err) begin
      phase_next = PH_IDLE;
    end else if (rd_data) begin
      peer_answered_next = 1'b1;
      if (rd_new) begin
        block_count_next = rx_blk;
        tries_used_next  = TRY_W'(1);
        tick_count_next  = '0;
        if (rd_short) begin
          phase_next = PH_IDLE;
        end
      end else if (limit_hit) begin
        phase_next = PH_IDLE;
      end else begin
        tries_used_next = tries_used + TRY_W'(1);
        tick_count_next = '0;
      end
    end else if (wr_ack && (phase == PH_WREQ)) begin
      if (rx_blk == '0) begin
        phase_next            = PH_WDATA;
        block_count_next      = next_blk;
        tries_used_next       = TRY_W'(1);
        tick_count_next       = '0;
        last_sent_length_next = DLEN_W'(next_len);
      end
    end else if (wr_ack) begin
      if (!ack_match) begin
        tries_used_next = TRY_W'(1);
      end else if (!cur_full) begin
        phase_next = PH_IDLE;
      end else begin
        block_count_next      = next_blk;
        tries_used_next       = TRY_W'(1);
        tick_count_next       = '0;
        last_sent_length_next = DLEN_W'(next_len);
      end
    end
  end

  // Result of the current event.
  res_t res;

  always_comb begin
    res = '0;
    priority if (ev_start) begin
      res.send_kind = KIND_REQ;
    end else if (ev_tick) begin
      if (tick_expire) begin
        if (limit_hit) begin
          res.status = STAT_RETRY;
        end else if ((phase == PH_WREQ) || ((phase == PH_READ) && !peer_answered)) begin
          res.send_kind = KIND_REQ;
        end else if (phase == PH_READ) begin
          res.send_kind  = KIND_ACK;
          res.send_block = BLK_W'(block_count);
        end else begin
          res.send_kind   = KIND_DATA;
          res.send_block  = BLK_W'(block_count);
          res.send_length = last_sent_length;
        end
      end
    end else if (ev_err) begin
      res.status     = STAT_PEER;
      res.peer_error = ir_ecode;
    end else if (rd_data) begin
      if (rd_new) begin
        res.store_payload = 1'b1;
        res.send_kind     = KIND_ACK;
        res.send_block    = BLK_W'(rx_blk);
        if (rd_short) begin
          res.status = STAT_DONE;
        end
      end else if (limit_hit) begin
        res.status = STAT_RETRY;
      end else begin
        res.send_kind  = KIND_ACK;
        res.send_block = BLK_W'(block_count);
      end
    end else if (wr_ack && (phase == PH_WREQ)) begin
      if (rx_blk == '0) begin
        res.send_kind   = KIND_DATA;
        res.send_block  = BLK_W'(next_blk);
        res.send_length = DLEN_W'(next_len);
      end
    end else if (wr_ack && ack_match) begin
      if (!cur_full) begin
        res.status = STAT_DONE;
      end else begin
        res.send_kind   = KIND_DATA;
        res.send_block  = BLK_W'(next_blk);
        res.send_length = DLEN_W'(next_len);
      end
    end
  end

  // State only moves when the event moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      block_count      <= '0;
      tries_used       <= '0;
      tick_count       <= '0;
      peer_answered    <= 1'b0;
      last_sent_length <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      block_count      <= block_count_next;
      tries_used       <= tries_used_next;
      tick_count       <= tick_count_next;
      peer_answered    <= peer_answered_next;
      last_sent_length <= last_sent_length_next;
    end
  end

  // Result register.
  res_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign send_kind     = out_res.send_kind;
  assign send_block    = out_res.send_block;
  assign send_length   = out_res.send_length;
  assign store_payload = out_res.store_payload;
  assign status        = out_res.status;
  assign peer_error    = out_res.peer_error;

endmodule

[rtl/tftp_checker.sv]
// Port-level checks on the result channel of the transfer controller.
`include "assert_macros.svh"

module tftp_checker
  import tftp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         send_kind,
  input logic [BLK_W-1:0]   send_block,
  input logic [DLEN_W-1:0]  send_length,
  input logic               store_payload,
  input logic [1:0]         status,
  input logic [ECODE_W-1:0] peer_error
);

  // The whole result payload, and whether its kind carries no block number.
  logic [2+BLK_W+DLEN_W+1+2+ECODE_W-1:0] out_bus;
  logic                                  no_block_kind;

  assign out_bus       = {send_kind, send_block, send_length, store_payload, status, peer_error};
  assign no_block_kind = (send_kind == KIND_NONE) || (send_kind == KIND_REQ);

  // A stalled result beat stays put.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_bus))

  // Requests and empty results carry no block number.
  `ASSERT_SAME(a_req_no_block, clk, rst, out_valid && no_block_kind, send_block == '0)

  // Only data beats carry a length.
  `ASSERT_SAME(a_len_only_data, clk, rst, out_valid && (send_kind != KIND_DATA), send_length == '0)

  // A payload to store is always acknowledged in the same beat.
  `ASSERT_SAME(a_store_acks, clk, rst, out_valid && store_payload, send_kind == KIND_ACK)

  // The peer error code shows only with a peer error status.
  `ASSERT_SAME(a_err_code, clk, rst, out_valid && (status != STAT_PEER), peer_error == '0)

endmodule

bind tftp_client_transfer_fsm tftp_checker u_tftp_checker (.*);
